/* rtl/rrwts_pkg.sv */
// Shared constants and types of the round-robin wake-tick scheduler.
package rrwts_pkg;

	localparam int MAX_TASKS  = 16;
	localparam int TICK_WIDTH = 32;
	localparam int IDX_W      = $clog2(MAX_TASKS);
	localparam int CNT_W      = $clog2(MAX_TASKS + 1);

	// Action codes carried by an input item.
	typedef enum logic [2:0] {
		ACT_TICK  = 3'd0,
		ACT_ADD   = 3'd1,
		ACT_DELAY = 3'd2,
		ACT_YIELD = 3'd3,
		ACT_WAKE  = 3'd4,
		ACT_WAIT  = 3'd5
	} action_t;

	// Status codes carried by a result item.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_UNKNOWN = 2'd2,
		ST_CLAMPED = 2'd3
	} status_t;

	// Configuration register word indexes.
	localparam logic REG_WAKE_WINDOW = 1'b0;

	localparam logic [TICK_WIDTH-1:0] WINDOW_RESET = {1'b1, {(TICK_WIDTH-1){1'b0}}};

endpackage

/* rtl/rrwts_if.sv */
// Valid/ready channel interfaces for scheduler requests and responses.
interface rrwts_in_if;
	import rrwts_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [2:0]            action;
	logic [TICK_WIDTH-1:0] amount;
	logic [IDX_W-1:0]      task_id;

	modport source (output valid, action, amount, task_id, input ready);
	modport sink   (input valid, action, amount, task_id, output ready);
endinterface

interface rrwts_out_if;
	import rrwts_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [IDX_W-1:0]      current_task;
	logic [TICK_WIDTH-1:0] tick_now;
	logic                  none_ready;
	logic [IDX_W-1:0]      added_index;
	logic [1:0]            status;

	modport source (output valid, current_task, tick_now, none_ready, added_index, status,
		input ready);
	modport sink   (input valid, current_task, tick_now, none_ready, added_index, status,
		output ready);
endinterface

/* rtl/round_robin_wake_tick_scheduler.sv */
// Top level of the round-robin wake-tick task scheduler.
// The block takes one action at a time. Tick, add, wake and unknown codes, and delay,
// yield and wait on an empty table, pass from execute to done without a scan. Delay, yield
// and wait on a filled table scan the task table, which lives in a memory read one entry
// per cycle through a registered read port: the scan stops at the first due task visited,
// or after task_count entries when no task is due. A new request is taken once the result has
// been placed in the output register, even while that result still waits for its transfer.
module round_robin_wake_tick_scheduler (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	rrwts_in_if.sink                req,
	rrwts_out_if.source             rsp
);
	import rrwts_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                state_q;
	logic [TICK_WIDTH-1:0] window_q;
	logic [TICK_WIDTH-1:0] ticks_q;
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      running_q;

	// Captured request.
	action_t               act_q;
	logic [TICK_WIDTH-1:0] amount_q;
	logic [IDX_W-1:0]      tid_q;

	// Result being built.
	logic                  none_q;
	logic [IDX_W-1:0]      added_q;
	status_t               status_q;

	// Scan bookkeeping.
	logic [IDX_W-1:0]      iss_idx_q;
	logic [CNT_W-1:0]      iss_left_q;
	logic                  rd_v_s1;
	logic [IDX_W-1:0]      rd_idx_s1;

	// Memory ports.
	logic                  wake_we;
	logic                  flag_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [TICK_WIDTH-1:0] wake_wdata;
	logic                  flag_wdata;
	logic                  mem_re;
	logic [TICK_WIDTH-1:0] wake_rdata;
	logic                  flag_rdata;

	logic                  out_valid_q;
	logic                  out_free;
	logic                  cfg_wr;

	// Combinational helpers for the execute cycle and the scan.
	logic                  over_window;
	logic [TICK_WIDTH-1:0] delay_amt;
	logic [TICK_WIDTH-1:0] wake_sum;
	logic [IDX_W-1:0]      start_idx;
	logic [CNT_W-1:0]      run_inc;
	logic [CNT_W-1:0]      iss_inc;
	logic [IDX_W-1:0]      iss_next;
	logic [TICK_WIDTH-1:0] elapsed;
	logic                  due;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_WAKE_WINDOW) ? window_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_wr && paddr[2] == REG_WAKE_WINDOW) begin
			window_q <= pwdata;
		end
	end

	// Delay amount clamp and new wake tick.
	assign over_window = amount_q >= window_q;
	always_comb begin
		delay_amt = amount_q;
		if (act_q == ACT_DELAY && over_window) begin
			delay_amt = (window_q == '0) ? '0 : window_q - 1'b1;
		end
	end
	assign wake_sum = ticks_q + delay_amt;

	// Ring successors of the running task and of the scan pointer.
	assign run_inc   = {1'b0, running_q} + 1'b1;
	assign start_idx = (run_inc >= count_q) ? '0 : run_inc[IDX_W-1:0];
	assign iss_inc   = {1'b0, iss_idx_q} + 1'b1;
	assign iss_next  = (iss_inc >= count_q) ? '0 : iss_inc[IDX_W-1:0];

	// Due test on the entry returned by the memory.
	assign elapsed = ticks_q - wake_rdata;
	assign due     = flag_rdata && (elapsed < window_q);

	// Table writes happen only in the execute cycle.
	always_comb begin
		wake_we    = 1'b0;
		flag_we    = 1'b0;
		mem_waddr  = running_q;
		wake_wdata = ticks_q;
		flag_wdata = 1'b1;
		if (state_q == S_EXEC) begin
			case (act_q)
				ACT_ADD: begin
					if (count_q < CNT_W'(MAX_TASKS)) begin
						mem_waddr = count_q[IDX_W-1:0];
						wake_we   = 1'b1;
						flag_we   = 1'b1;
					end
				end
				ACT_DELAY: begin
					if (count_q != '0) begin
						wake_wdata = wake_sum;
						wake_we    = 1'b1;
					end
				end
				ACT_WAIT: begin
					if (count_q != '0) begin
						wake_wdata = wake_sum;
						wake_we    = !over_window;
						flag_wdata = 1'b0;
						flag_we    = over_window;
					end
				end
				ACT_WAKE: begin
					if ({1'b0, tid_q} < count_q) begin
						mem_waddr = tid_q;
						wake_we   = 1'b1;
						flag_we   = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign mem_re = (state_q == S_SCAN) && (iss_left_q != '0);

	rrwts_ram #(.DEPTH(MAX_TASKS), .WIDTH(TICK_WIDTH)) u_wake_ram (
		.clk   (clk),
		.we    (wake_we),
		.waddr (mem_waddr),
		.wdata (wake_wdata),
		.re    (mem_re),
		.raddr (iss_idx_q),
		.rdata (wake_rdata)
	);

	rrwts_ram #(.DEPTH(MAX_TASKS), .WIDTH(1)) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (mem_waddr),
		.wdata (flag_wdata),
		.re    (mem_re),
		.raddr (iss_idx_q),
		.rdata (flag_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;

	// Sequencer: capture, execute, scan, and hand off the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ticks_q    <= '0;
			count_q    <= '0;
			running_q  <= '0;
			iss_left_q <= '0;
			rd_v_s1    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					rd_v_s1 <= 1'b0;
					if (req.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (act_q)
						ACT_TICK: ticks_q <= ticks_q + 1'b1;
						ACT_ADD: begin
							if (count_q < CNT_W'(MAX_TASKS)) begin
								count_q <= count_q + 1'b1;
							end
						end
						ACT_DELAY, ACT_YIELD, ACT_WAIT: begin
							if (count_q != '0) begin
								state_q    <= S_SCAN;
								iss_left_q <= count_q;
							end
						end
						default: begin
						end
					endcase
				end
				S_SCAN: begin
					rd_v_s1 <= mem_re;
					if (mem_re) begin
						iss_left_q <= iss_left_q - 1'b1;
					end
					if (rd_v_s1 && due) begin
						running_q <= rd_idx_s1;
						state_q   <= S_DONE;
						rd_v_s1   <= 1'b0;
					end else if (rd_v_s1 && iss_left_q == '0) begin
						state_q <= S_DONE;
						rd_v_s1 <= 1'b0;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers of the request, the result and the scan pointer.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			act_q    <= action_t'(req.action);
			amount_q <= req.amount;
			tid_q    <= req.task_id;
		end
		if (state_q == S_EXEC) begin
			none_q    <= 1'b0;
			added_q   <= '0;
			status_q  <= ST_OK;
			iss_idx_q <= start_idx;
			case (act_q)
				ACT_ADD: begin
					if (count_q < CNT_W'(MAX_TASKS)) begin
						added_q <= count_q[IDX_W-1:0];
					end else begin
						status_q <= ST_FULL;
					end
				end
				ACT_DELAY: begin
					if (count_q == '0) begin
						status_q <= ST_UNKNOWN;
						none_q   <= 1'b1;
					end else if (over_window) begin
						status_q <= ST_CLAMPED;
					end
				end
				ACT_WAIT: begin
					if (count_q == '0) begin
						status_q <= ST_UNKNOWN;
						none_q   <= 1'b1;
					end
				end
				ACT_YIELD: begin
					if (count_q == '0) begin
						none_q <= 1'b1;
					end
				end
				ACT_WAKE: begin
					if ({1'b0, tid_q} >= count_q) begin
						status_q <= ST_UNKNOWN;
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_SCAN) begin
			if (mem_re) begin
				iss_idx_q <= iss_next;
				rd_idx_s1 <= iss_idx_q;
			end
			if (rd_v_s1 && !due && iss_left_q == '0) begin
				none_q <= 1'b1;
			end
		end
	end

	// Output register: loaded when the result is done and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp.current_task <= running_q;
			rsp.tick_now     <= ticks_q;
			rsp.none_ready   <= none_q;
			rsp.added_index  <= added_q;
			rsp.status       <= status_q;
		end
	end

	assign rsp.valid = out_valid_q;

	// The running task always lies inside the filled part of the table.
	a_running_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) ? (running_q == '0) : ({1'b0, running_q} < count_q))
		else $error("running task outside the task table");

	// The task count never exceeds the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TASKS))
		else $error("task count beyond table size");

	// The tick counter moves only in the execute cycle.
	a_ticks_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_EXEC) |=> $stable(ticks_q))
		else $error("tick counter changed outside execute");

	// Read data is only pending while a scan runs.
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (state_q == S_SCAN))
		else $error("memory read pending outside a scan");

endmodule

/* rtl/rrwts_ram.sv */
// Simple dual-port synchronous RAM with a registered read port.
module rrwts_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
